// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sequencer and datapath of the PID motor drive.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ppmd_pkg.sv =====
// Package with the types and constants of the PID motor drive.
package ppmd_pkg;

    // Field widths fixed by the interface.
    localparam int GAIN_WIDTH      = 16;
    localparam int DUTY_WIDTH      = 15;
    localparam int OUT_TDATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH   = 2;

    // Duty scaling: |out| * round(200/pi * 2^16) >> 28 gives percent in Q7.8.
    localparam int MAG_WIDTH      = 23;
    localparam int DUTY_MUL_WIDTH = 22;
    localparam int DUTY_PROD_W    = MAG_WIDTH + DUTY_MUL_WIDTH;
    localparam int DUTY_SHIFT     = 28;
    localparam int DUTY_SHIFT_W   = DUTY_PROD_W - DUTY_SHIFT;
    localparam logic [DUTY_MUL_WIDTH-1:0] DUTY_MUL  = 22'd4172151;
    localparam logic [MAG_WIDTH-1:0]      OUT_CLAMP = 23'd4194304;
    localparam logic [DUTY_WIDTH-1:0]     DUTY_MAX  = 15'd25600;

    // Opcodes carried in the input tuser.
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DERIV_GAIN = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PMUL,
        S_IMUL,
        S_DMUL,
        S_ACC,
        S_MAG,
        S_DUTY,
        S_OUT
    } t_state;

    // Operand pair for the shared multiplier.
    typedef enum logic [1:0] {
        MS_PROP,
        MS_INTEG,
        MS_DERIV
    } t_mul_sel;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic     load_err;
        logic     clear;
        logic     integ_upd;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     mag_load;
        logic     duty_load;
        logic     out_load;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ===== rtl/ppmd_ctrl.sv =====
// Sequencer that steps the PID datapath through one control item.
`include "assert_macros.svh"

module ppmd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    output logic              o_in_ready,
    input  ppmd_pkg::t_status i_status,
    output ppmd_pkg::t_cmd    o_cmd
);
    import ppmd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.mul_sel = MS_PROP;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_opcode == OP_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.load_err = 1'b1;
                        n_state        = S_PMUL;
                    end
                end
            end
            S_PMUL: begin
                o_cmd.integ_upd = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MS_PROP;
                n_state         = S_IMUL;
            end
            S_IMUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MS_INTEG;
                o_cmd.acc_load = 1'b1;
                n_state        = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DERIV;
                o_cmd.acc_add = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag_load = 1'b1;
                n_state        = S_DUTY;
            end
            S_DUTY: begin
                o_cmd.duty_load = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                // Wait until the output register can take the result.
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // An accepted control step starts the multiply sequence.
    `ASSERT_CLK(a_step_starts, i_clk, i_rst_n, (i_in_valid && o_in_ready && i_opcode == OP_STEP) |=> (r_state == S_PMUL), "control step did not start the sequence")
    // A clear transfer leaves the sequencer in the idle state.
    `ASSERT_CLK(a_clear_idle, i_clk, i_rst_n, (i_in_valid && o_in_ready && i_opcode == OP_CLEAR) |=> (r_state == S_IDLE), "clear transfer left the idle state")

endmodule

// ===== rtl/ppmd_datapath.sv =====
// Datapath of the PID motor drive: error, integral, shared multiplier, duty scaling.
`include "assert_macros.svh"

module ppmd_datapath #(
    parameter int ANGLE_WIDTH = 16,
    parameter int SUM_WIDTH   = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ppmd_pkg::t_cmd                         i_cmd,
    output ppmd_pkg::t_status                      o_status,
    input  logic signed [ANGLE_WIDTH-1:0]          i_setpoint_angle,
    input  logic signed [ANGLE_WIDTH-1:0]          i_measured_angle,
    input  logic [ppmd_pkg::GAIN_WIDTH-1:0]        i_prop_gain,
    input  logic [ppmd_pkg::GAIN_WIDTH-1:0]        i_integ_gain,
    input  logic [ppmd_pkg::GAIN_WIDTH-1:0]        i_deriv_gain,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_direction,
    output logic [ppmd_pkg::DUTY_WIDTH-1:0]        o_duty_magnitude
);
    import ppmd_pkg::*;

    // Error, error difference, multiplier operand, product and accumulator widths.
    localparam int EW  = ANGLE_WIDTH + 1;
    localparam int DW  = ANGLE_WIDTH + 2;
    localparam int MW  = (SUM_WIDTH > DW) ? SUM_WIDTH : DW;
    localparam int PW  = MW + GAIN_WIDTH + 1;
    localparam int AW  = PW + 2;
    localparam int SAW = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;

    localparam logic signed [SAW-1:0] SUM_HI = SAW'({1'b0, {(SUM_WIDTH-1){1'b1}}});
    localparam logic signed [SAW-1:0] SUM_LO = ~SUM_HI;

    logic signed [EW-1:0]         r_err;
    logic signed [EW-1:0]         r_prev;
    logic signed [DW-1:0]         r_diff;
    logic signed [SUM_WIDTH-1:0]  r_sum;
    logic signed [PW-1:0]         r_prod;
    logic signed [AW-1:0]         r_acc;
    logic [MAG_WIDTH-1:0]         r_mag;
    logic                         r_dir;
    logic [DUTY_PROD_W-1:0]       r_duty_prod;
    logic                         r_out_dir;
    logic [DUTY_WIDTH-1:0]        r_out_duty;
    logic                         r_out_valid;

    logic signed [EW-1:0]         w_err;
    logic signed [SAW-1:0]        w_sum_ext;
    logic signed [SUM_WIDTH-1:0]  w_sum_sat;
    logic signed [DW-1:0]         w_diff;
    logic [GAIN_WIDTH-1:0]        w_mul_gain;
    logic signed [MW-1:0]         w_mul_op;
    logic signed [PW-1:0]         w_prod;
    logic                         w_pos;
    logic [AW-1:0]                w_abs;
    logic [MAG_WIDTH-1:0]         w_mag;
    logic [DUTY_PROD_W-1:0]       w_scaled;
    logic [DUTY_SHIFT_W-1:0]      w_shift;
    logic [DUTY_WIDTH-1:0]        w_duty;

    // Error and saturating integral update.
    assign w_err     = EW'(i_setpoint_angle) - EW'(i_measured_angle);
    assign w_sum_ext = SAW'(r_sum) + SAW'(r_err);
    assign w_diff    = DW'(r_err) - DW'(r_prev);

    always_comb begin
        if (w_sum_ext > SUM_HI) begin
            w_sum_sat = SUM_WIDTH'(SUM_HI);
        end else if (w_sum_ext < SUM_LO) begin
            w_sum_sat = SUM_WIDTH'(SUM_LO);
        end else begin
            w_sum_sat = SUM_WIDTH'(w_sum_ext);
        end
    end

    // Operand selection for the shared gain multiplier.
    always_comb begin
        case (i_cmd.mul_sel)
            MS_PROP: begin
                w_mul_gain = i_prop_gain;
                w_mul_op   = MW'(r_err);
            end
            MS_INTEG: begin
                w_mul_gain = i_integ_gain;
                w_mul_op   = MW'(r_sum);
            end
            MS_DERIV: begin
                w_mul_gain = i_deriv_gain;
                w_mul_op   = MW'(r_diff);
            end
            default: begin
                w_mul_gain = '0;
                w_mul_op   = '0;
            end
        endcase
    end

    assign w_prod = PW'($signed({1'b0, w_mul_gain})) * PW'(w_mul_op);

    // Sign and clamped magnitude of the PID sum.
    assign w_pos = !r_acc[AW-1] && (r_acc != '0);
    assign w_abs = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
    assign w_mag = (w_abs > AW'(OUT_CLAMP)) ? OUT_CLAMP : w_abs[MAG_WIDTH-1:0];

    // Percent scaling and limit at full duty.
    assign w_scaled = DUTY_PROD_W'(r_mag) * DUTY_PROD_W'(DUTY_MUL);
    assign w_shift  = r_duty_prod[DUTY_PROD_W-1:DUTY_SHIFT];
    assign w_duty   = (w_shift > DUTY_SHIFT_W'(DUTY_MAX)) ? DUTY_MAX
                                                          : w_shift[DUTY_WIDTH-1:0];

    // Controller state kept across items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_cmd.clear) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_cmd.integ_upd) begin
            r_sum  <= w_sum_sat;
            r_prev <= r_err;
        end
    end

    // Working registers of one item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_err <= w_err;
        end
        if (i_cmd.integ_upd) begin
            r_diff <= w_diff;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_load) begin
            r_acc <= AW'(r_prod);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + AW'(r_prod);
        end
        if (i_cmd.mag_load) begin
            r_mag <= w_mag;
            r_dir <= !w_pos;
        end
        if (i_cmd.duty_load) begin
            r_duty_prod <= w_scaled;
        end
        if (i_cmd.out_load) begin
            r_out_dir  <= r_dir;
            r_out_duty <= w_duty;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_direction       = r_out_dir;
    assign o_duty_magnitude  = r_out_duty;

    // A clear leaves the integral and the last error at zero.
    `ASSERT_CLK(a_clear_zeroes, i_clk, i_rst_n, i_cmd.clear |=> (r_sum == '0 && r_prev == '0), "clear did not zero the controller state")
    // A presented result never exceeds full duty.
    `ASSERT_NEVER(a_duty_bounded, i_clk, i_rst_n, o_out_valid && (o_duty_magnitude > DUTY_MAX), "duty magnitude above full scale")

endmodule

// ===== rtl/position_pid_motor_drive.sv =====
// Top level of the positional PID controller with motor-drive output.
//
// Each input transfer carries an opcode in tuser and a setpoint and measured
// angle in tdata. After a control step is accepted, the block takes no new item
// until its sequence is through: the shared 17-bit by operand-width gain
// multiplier is used in turn for the proportional, integral and derivative
// terms, followed by accumulation, magnitude clamp, duty scaling and the load of
// the output register. That load waits while the output register is still full,
// and the result is then presented from it. A clear item produces no result.
// Gain registers may be written only while no item is in progress.
module position_pid_motor_drive #(
    parameter int ANGLE_WIDTH = 16,
    parameter int SUM_WIDTH   = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Input stream.
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: setpoint_angle, measured_angle, zero fill to whole bytes
    input  logic [((2*ANGLE_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    // tuser: opcode
    input  logic [0:0]                              i_s_axis_tuser,
    // Output stream.
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // tdata: direction, duty_magnitude
    output logic [ppmd_pkg::OUT_TDATA_WIDTH-1:0]    o_m_axis_tdata,
    // Configuration write port.
    input  logic                                    i_cfg_we,
    input  logic [ppmd_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_idx,
    input  logic [ppmd_pkg::GAIN_WIDTH-1:0]         i_cfg_wdata
);
    import ppmd_pkg::*;

    logic [GAIN_WIDTH-1:0] r_prop_gain;
    logic [GAIN_WIDTH-1:0] r_integ_gain;
    logic [GAIN_WIDTH-1:0] r_deriv_gain;

    t_cmd                  w_cmd;
    t_status               w_status;
    logic                  w_direction;
    logic [DUTY_WIDTH-1:0] w_duty;

    // Gain registers; writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= 16'd256;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:  r_prop_gain  <= i_cfg_wdata;
                REG_INTEG_GAIN: r_integ_gain <= i_cfg_wdata;
                REG_DERIV_GAIN: r_deriv_gain <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    ppmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_opcode   (i_s_axis_tuser[0]),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and output register.
    ppmd_datapath #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_setpoint_angle (i_s_axis_tdata[ANGLE_WIDTH-1:0]),
        .i_measured_angle (i_s_axis_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
        .i_prop_gain      (r_prop_gain),
        .i_integ_gain     (r_integ_gain),
        .i_deriv_gain     (r_deriv_gain),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_direction      (w_direction),
        .o_duty_magnitude (w_duty)
    );

    assign o_m_axis_tdata = {w_duty, w_direction};

endmodule

// ===== tb/pid_drive_checker.sv =====
// Checker for the PID motor drive: predicts each duty command and compares it.
`timescale 1ns / 1ps

module pid_drive_checker
    import ppmd_pkg::*;
#(
    parameter int ANGLE_W = 16,
    parameter int SUM_W   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream as seen at the block.
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // tdata: setpoint_angle, measured_angle, zero fill to whole bytes
    input  logic [((2*ANGLE_W+7)/8)*8-1:0]      i_s_tdata,
    // tuser: opcode
    input  logic [0:0]                          i_s_tuser,
    // Output stream as seen at the block.
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: direction, duty_magnitude
    input  logic [OUT_TDATA_WIDTH-1:0]          i_m_tdata,
    // Gain register writes.
    input  logic                                i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]            i_cfg_idx,
    input  logic [GAIN_WIDTH-1:0]               i_cfg_wdata,
    // Status for the stimulus side.
    output int                                  o_pending,
    output int                                  o_fail_count
);

    // Duty scaling: |sum| in Q.20 times round(200/pi * 2^16), shifted down to Q7.8.
    localparam longint SUM_CLAMP   = 64'sd4194304;
    localparam longint DUTY_SCALE  = 64'sd4172151;
    localparam int     DUTY_RSHIFT = 28;
    localparam longint DUTY_CEIL   = 64'sd25600;
    localparam longint ACC_MAX     = (64'sd1 <<< (SUM_W - 1)) - 1;
    localparam longint ACC_MIN     = -ACC_MAX - 1;

    typedef struct packed {
        logic                  direction;
        logic [DUTY_WIDTH-1:0] duty_magnitude;
    } drive_cmd_t;

    // Controller state mirrored from the transfers seen on the ports.
    logic [GAIN_WIDTH-1:0] kp;
    logic [GAIN_WIDTH-1:0] ki;
    logic [GAIN_WIDTH-1:0] kd;
    longint                integ_acc;
    longint                last_err;
    drive_cmd_t            drive_q[$];
    int                    fails = 0;

    // One control step: updates the integral and last error, returns the drive command.
    function automatic drive_cmd_t predict_drive(input logic signed [ANGLE_W-1:0] setpoint,
                                                 input logic signed [ANGLE_W-1:0] measured);
        longint     err;
        longint     total;
        longint     mag;
        longint     duty;
        drive_cmd_t cmd;
        err = longint'(setpoint) - longint'(measured);
        integ_acc = integ_acc + err;
        if (integ_acc > ACC_MAX) integ_acc = ACC_MAX;
        if (integ_acc < ACC_MIN) integ_acc = ACC_MIN;
        // At these widths the integral term stays far inside 64 bits.
        total = longint'(kp) * err + longint'(ki) * integ_acc
              + longint'(kd) * (err - last_err);
        last_err = err;
        cmd.direction = (total > 0) ? 1'b0 : 1'b1;
        mag = (total < 0) ? -total : total;
        if (mag > SUM_CLAMP) mag = SUM_CLAMP;
        duty = (mag * DUTY_SCALE) >>> DUTY_RSHIFT;
        if (duty > DUTY_CEIL) duty = DUTY_CEIL;
        cmd.duty_magnitude = DUTY_WIDTH'(duty);
        return cmd;
    endfunction

    // Track register writes and input transfers, and check each output transfer.
    always @(posedge i_clk) begin : watch
        drive_cmd_t want;
        drive_cmd_t got;
        if (!i_rst_n) begin
            kp = 16'd256;
            ki = '0;
            kd = '0;
            integ_acc = 0;
            last_err = 0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PROP_GAIN:  kp = i_cfg_wdata;
                    REG_INTEG_GAIN: ki = i_cfg_wdata;
                    REG_DERIV_GAIN: kd = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == OP_CLEAR) begin
                    integ_acc = 0;
                    last_err = 0;
                end else begin
                    drive_q.push_back(predict_drive(i_s_tdata[ANGLE_W-1:0],
                                                    i_s_tdata[2*ANGLE_W-1:ANGLE_W]));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.direction      = i_m_tdata[0];
                got.duty_magnitude = i_m_tdata[DUTY_WIDTH:1];
                if (drive_q.size() == 0) begin
                    $error("unexpected transfer: direction %0d duty_magnitude %0d",
                           got.direction, got.duty_magnitude);
                    fails++;
                end else begin
                    want = drive_q.pop_front();
                    if (got.direction !== want.direction) begin
                        $error("direction mismatch: expected %0d, actual %0d",
                               want.direction, got.direction);
                        fails++;
                    end
                    if (got.duty_magnitude !== want.duty_magnitude) begin
                        $error("duty_magnitude mismatch: expected %0d, actual %0d",
                               want.duty_magnitude, got.duty_magnitude);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= drive_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives the PID motor drive, hosts the checker and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
    import ppmd_pkg::*;

    localparam int ANGLE_W         = 16;
    localparam int SUM_W           = 32;
    localparam int IN_DATA_W       = ((2*ANGLE_W+7)/8)*8;
    localparam int ANGLE_MAX       = 32767;
    localparam int ANGLE_MIN       = -32768;
    localparam int SETTLE_CYCLES   = 12;
    localparam int ITEMS_PER_PHASE = 250;
    // Index with no register behind it.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_LIGHT
    } rx_mode_t;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [IN_DATA_W-1:0]     i_s_axis_tdata  = '0;
    logic [0:0]               i_s_axis_tuser  = '0;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] o_m_axis_tdata;
    logic                     i_cfg_we        = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx       = '0;
    logic [GAIN_WIDTH-1:0]    i_cfg_wdata     = '0;

    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_left      = 0;
    int       burst_left   = 0;
    int       chk_pending;
    int       chk_fail_count;

    position_pid_motor_drive #(
        .ANGLE_WIDTH (ANGLE_W),
        .SUM_WIDTH   (SUM_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    pid_drive_checker #(
        .ANGLE_W (ANGLE_W),
        .SUM_W   (SUM_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (chk_pending),
        .o_fail_count (chk_fail_count)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: switches at random between stall patterns.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_m_axis_tready <= 1'b1;
            RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_m_axis_tready <= (rx_left % 8 == 0);
            default:   i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Presents one item and waits for its transfer; valid stays high afterwards.
    task automatic send_item(input logic op,
                             input logic signed [ANGLE_W-1:0] setpoint,
                             input logic signed [ANGLE_W-1:0] measured);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {measured, setpoint};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Same as send_item, but the sender runs in bursts with random gaps.
    task automatic paced_item(input logic op,
                              input logic signed [ANGLE_W-1:0] setpoint,
                              input logic signed [ANGLE_W-1:0] measured);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_item(op, setpoint, measured);
    endtask

    // Holds the sender until every predicted command has come out, then lets clears finish.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_gains(input logic [GAIN_WIDTH-1:0] prop,
                             input logic [GAIN_WIDTH-1:0] integ,
                             input logic [GAIN_WIDTH-1:0] deriv);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_PROP_GAIN;
        i_cfg_wdata <= prop;
        @(posedge i_clk);
        i_cfg_idx   <= REG_INTEG_GAIN;
        i_cfg_wdata <= integ;
        @(posedge i_clk);
        i_cfg_idx   <= REG_DERIV_GAIN;
        i_cfg_wdata <= deriv;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly small tracking errors, some full-range angles and the odd clear.
    task automatic random_item();
        int pick;
        int meas_val;
        logic signed [ANGLE_W-1:0] setpoint;
        pick = $urandom_range(0, 15);
        setpoint = ANGLE_W'($urandom);
        if (pick == 0) begin
            paced_item(OP_CLEAR, setpoint, ANGLE_W'($urandom));
        end else if (pick < 11) begin
            meas_val = int'(setpoint) + int'($urandom_range(0, 1600)) - 800;
            if (meas_val > ANGLE_MAX) meas_val = ANGLE_MAX;
            if (meas_val < ANGLE_MIN) meas_val = ANGLE_MIN;
            paced_item(OP_STEP, setpoint, ANGLE_W'(meas_val));
        end else begin
            paced_item(OP_STEP, setpoint, ANGLE_W'($urandom));
        end
    endtask

    // Main stimulus sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains: zero output, both error extremes, smallest errors, a clear.
        send_item(OP_STEP, 16'sd0, 16'sd0);
        send_item(OP_STEP, 16'sd32767, -16'sd32768);
        send_item(OP_STEP, -16'sd32768, 16'sd32767);
        send_item(OP_STEP, 16'sd1, 16'sd0);
        send_item(OP_STEP, 16'sd0, 16'sd1);
        send_item(OP_STEP, 16'sd32767, 16'sd32767);
        send_item(OP_STEP, 16'sd1234, -16'sd567);
        send_item(OP_CLEAR, 16'sd32767, -16'sd1);
        send_item(OP_STEP, -16'sd32768, -16'sd32768);

        // A write to the unused index must leave the gains alone.
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_SPARE;
        i_cfg_wdata <= 16'hFFFF;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        send_item(OP_STEP, 16'sd1, 16'sd0);

        // Integral and derivative only, across a clear.
        drain_results();
        set_gains(16'd0, 16'hFFFF, 16'hFFFF);
        send_item(OP_STEP, 16'sd10, 16'sd0);
        send_item(OP_STEP, 16'sd20, 16'sd0);
        send_item(OP_STEP, -16'sd5, 16'sd0);
        send_item(OP_STEP, 16'sd0, 16'sd0);
        send_item(OP_CLEAR, 16'sd0, 16'sd0);
        send_item(OP_STEP, 16'sd10, 16'sd0);
        send_item(OP_STEP, -16'sd32768, 16'sd32767);

        // Largest proportional gain on single-count errors.
        drain_results();
        set_gains(16'hFFFF, 16'd0, 16'd0);
        send_item(OP_STEP, 16'sd1, 16'sd0);
        send_item(OP_STEP, 16'sd0, 16'sd1);
        send_item(OP_STEP, -16'sd1, 16'sd0);

        // Random phases, each with its own gain setting and a pause halfway.
        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            case (ph)
                0: set_gains(GAIN_WIDTH'($urandom), GAIN_WIDTH'($urandom),
                             GAIN_WIDTH'($urandom));
                1: set_gains(16'd0, 16'd0, 16'd0);
                2: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: set_gains(GAIN_WIDTH'($urandom_range(0, 512)),
                             GAIN_WIDTH'($urandom_range(0, 16)),
                             GAIN_WIDTH'($urandom_range(0, 512)));
                4: set_gains(GAIN_WIDTH'($urandom), GAIN_WIDTH'($urandom_range(0, 64)),
                             GAIN_WIDTH'($urandom));
                default: set_gains(16'd256, 16'd0, 16'd0);
            endcase
            if ($urandom_range(0, 1) == 1) begin
                paced_item(OP_CLEAR, ANGLE_W'($urandom), ANGLE_W'($urandom));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) drain_results();
                random_item();
            end
        end

        drain_results();
        if (chk_fail_count == 0) begin
            $display("position_pid_motor_drive verification clean");
        end else begin
            $display("position_pid_motor_drive verification failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #80_000_000;
        $display("position_pid_motor_drive verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ppmd_pkg.sv
rtl/ppmd_ctrl.sv
rtl/ppmd_datapath.sv
rtl/position_pid_motor_drive.sv
tb/pid_drive_checker.sv
tb/tb_top.sv
